// ===== hdl/goc_pkg.sv =====
package goc_pkg;

    // width of the motion tick counter
    localparam int COUNT_BITS   = 12;
    localparam int TIMEOUT_BITS = 12;
    localparam int DELAY_BITS   = 8;
    localparam int PHASE_BITS   = 2;
    localparam int CMP_BITS     = (COUNT_BITS > TIMEOUT_BITS) ? COUNT_BITS : TIMEOUT_BITS;

    localparam logic [COUNT_BITS-1:0] MOVE_MAX = '1;

    // configuration port
    localparam int ADDR_BITS = 4;
    localparam int DATA_BITS = 32;
    localparam int IDX_BITS  = 2;

    localparam logic [IDX_BITS-1:0] REG_TIMEOUT = 2'd0;
    localparam logic [IDX_BITS-1:0] REG_RECHECK = 2'd1;
    localparam logic [IDX_BITS-1:0] REG_BLINK   = 2'd2;

    localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = 12'd3600;
    localparam logic [DELAY_BITS-1:0]   RECHECK_RESET = 8'd30;
    localparam logic [DELAY_BITS-1:0]   BLINK_RESET   = 8'd10;

    localparam logic [PHASE_BITS-1:0] LAST_PHASE = 2'd2;

    typedef enum logic [2:0] {
        ST_INIT    = 3'd0,
        ST_OPENING = 3'd1,
        ST_CLOSING = 3'd2,
        ST_CLOSED  = 3'd3,
        ST_OPEN    = 3'd4,
        ST_EMERG   = 3'd5,
        ST_ERROR   = 3'd6,
        ST_WAIT    = 3'd7
    } t_state;

    typedef struct packed {
        logic [TIMEOUT_BITS-1:0] timeout_ticks;
        logic [DELAY_BITS-1:0]   recheck_ticks;
        logic [DELAY_BITS-1:0]   blink_ticks;
    } t_cfg;

    typedef struct packed {
        logic open_limit;
        logic close_limit;
        logic photocell_block;
        logic close_cmd;
        logic open_cmd;
    } t_switches;

    typedef struct packed {
        logic       motor_open;
        logic       motor_close;
        logic       led_moving;
        logic       led_alarm;
        logic [2:0] state_code;
    } t_result;

endpackage

// ===== hdl/goc_regs.sv =====
module goc_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [goc_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [goc_pkg::DATA_BITS-1:0]  pwdata,
    output logic [goc_pkg::DATA_BITS-1:0]  prdata,
    output logic                           pready,
    output goc_pkg::t_cfg                  o_cfg
);

    goc_pkg::t_cfg                r_cfg;
    logic                         wr_en;
    logic [goc_pkg::IDX_BITS-1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[goc_pkg::ADDR_BITS-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout_ticks <= goc_pkg::TIMEOUT_RESET;
            r_cfg.recheck_ticks <= goc_pkg::RECHECK_RESET;
            r_cfg.blink_ticks   <= goc_pkg::BLINK_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                goc_pkg::REG_TIMEOUT: begin
                    r_cfg.timeout_ticks <= pwdata[goc_pkg::TIMEOUT_BITS-1:0];
                end
                goc_pkg::REG_RECHECK: begin
                    r_cfg.recheck_ticks <= pwdata[goc_pkg::DELAY_BITS-1:0];
                end
                goc_pkg::REG_BLINK: begin
                    r_cfg.blink_ticks <= pwdata[goc_pkg::DELAY_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            goc_pkg::REG_TIMEOUT: prdata = goc_pkg::DATA_BITS'(r_cfg.timeout_ticks);
            goc_pkg::REG_RECHECK: prdata = goc_pkg::DATA_BITS'(r_cfg.recheck_ticks);
            goc_pkg::REG_BLINK:   prdata = goc_pkg::DATA_BITS'(r_cfg.blink_ticks);
            default:              prdata = '0;
        endcase
    end

endmodule

// ===== hdl/goc_fsm.sv =====
module goc_fsm (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  goc_pkg::t_switches i_sw,
    input  goc_pkg::t_cfg      i_cfg,
    output goc_pkg::t_result   o_result
);

    goc_pkg::t_state                   r_state, n_state;
    goc_pkg::t_state                   r_return, n_return;
    logic [goc_pkg::COUNT_BITS-1:0]    r_move, n_move;
    logic [goc_pkg::DELAY_BITS-1:0]    r_delay, n_delay;
    logic [goc_pkg::PHASE_BITS-1:0]    r_phase, n_phase;

    logic [goc_pkg::COUNT_BITS-1:0]    move_base;
    logic [goc_pkg::DELAY_BITS:0]      delay_inc;
    logic                              timed_out;
    logic                              both_limits;

    // motion counter, taken before the transition
    always_comb begin
        move_base = i_sw.open_cmd ? '0 : r_move;
        if (r_state == goc_pkg::ST_OPENING || r_state == goc_pkg::ST_CLOSING) begin
            n_move = (move_base == goc_pkg::MOVE_MAX) ? move_base
                                                      : move_base + 1'b1;
        end else begin
            n_move = '0;
        end
        timed_out = (goc_pkg::CMP_BITS'(n_move) >= goc_pkg::CMP_BITS'(i_cfg.timeout_ticks))
                 || (n_move == goc_pkg::MOVE_MAX);
    end

    assign delay_inc   = {1'b0, r_delay} + 1'b1;
    assign both_limits = i_sw.open_limit && i_sw.close_limit;

    // next state
    always_comb begin
        n_state  = r_state;
        n_return = r_return;
        n_delay  = r_delay;
        n_phase  = r_phase;
        case (r_state)
            goc_pkg::ST_INIT, goc_pkg::ST_CLOSED, goc_pkg::ST_OPEN: begin
                n_state = goc_pkg::ST_WAIT;
            end
            goc_pkg::ST_WAIT: begin
                if (both_limits) begin
                    n_state = goc_pkg::ST_ERROR;
                end else if (!i_sw.open_limit && !i_sw.close_limit
                             && !i_sw.photocell_block) begin
                    n_state = goc_pkg::ST_CLOSING;
                end else if (i_sw.open_cmd && !i_sw.photocell_block
                             && !i_sw.open_limit) begin
                    n_state = goc_pkg::ST_OPENING;
                end else if (i_sw.close_cmd && !i_sw.photocell_block) begin
                    n_state = goc_pkg::ST_CLOSING;
                end else if (i_sw.open_cmd && !i_sw.photocell_block) begin
                    n_state = goc_pkg::ST_OPENING;
                end else if (i_sw.photocell_block) begin
                    n_state = goc_pkg::ST_EMERG;
                end
            end
            goc_pkg::ST_OPENING: begin
                if (both_limits)               n_state = goc_pkg::ST_ERROR;
                else if (i_sw.open_limit)      n_state = goc_pkg::ST_OPEN;
                else if (i_sw.photocell_block) n_state = goc_pkg::ST_EMERG;
                else if (i_sw.close_cmd)       n_state = goc_pkg::ST_CLOSING;
                else if (timed_out)            n_state = goc_pkg::ST_ERROR;
            end
            goc_pkg::ST_CLOSING: begin
                if (both_limits)               n_state = goc_pkg::ST_ERROR;
                else if (i_sw.close_limit)     n_state = goc_pkg::ST_CLOSED;
                else if (i_sw.photocell_block) n_state = goc_pkg::ST_EMERG;
                else if (i_sw.open_cmd)        n_state = goc_pkg::ST_OPENING;
                else if (timed_out)            n_state = goc_pkg::ST_ERROR;
            end
            goc_pkg::ST_EMERG: begin
                if (delay_inc >= {1'b0, i_cfg.recheck_ticks}) begin
                    n_delay = '0;
                    if (!i_sw.photocell_block) n_state = r_return;
                end else begin
                    n_delay = delay_inc[goc_pkg::DELAY_BITS-1:0];
                end
            end
            default: begin
                // error blink
                if (delay_inc >= {1'b0, i_cfg.blink_ticks}) begin
                    n_delay = '0;
                    if (r_phase >= goc_pkg::LAST_PHASE) begin
                        n_phase = '0;
                        n_state = goc_pkg::ST_WAIT;
                    end else begin
                        n_phase = r_phase + 1'b1;
                    end
                end else begin
                    n_delay = delay_inc[goc_pkg::DELAY_BITS-1:0];
                end
            end
        endcase
        // entry actions
        if (n_state == goc_pkg::ST_EMERG && r_state != goc_pkg::ST_EMERG) begin
            n_return = r_state;
            n_delay  = '0;
        end
        if (n_state == goc_pkg::ST_ERROR && r_state != goc_pkg::ST_ERROR) begin
            n_delay = '0;
            n_phase = '0;
        end
    end

    // drives of the state being entered
    always_comb begin
        o_result.motor_open  = (n_state == goc_pkg::ST_OPENING);
        o_result.motor_close = (n_state == goc_pkg::ST_CLOSING);
        o_result.led_moving  = (n_state == goc_pkg::ST_OPENING)
                            || (n_state == goc_pkg::ST_CLOSING);
        o_result.led_alarm   = (n_state == goc_pkg::ST_EMERG)
                            || (n_state == goc_pkg::ST_ERROR && !n_phase[0]);
        o_result.state_code  = n_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= goc_pkg::ST_INIT;
            r_return <= goc_pkg::ST_INIT;
            r_move   <= '0;
            r_delay  <= '0;
            r_phase  <= '0;
        end else if (i_accept) begin
            r_state  <= n_state;
            r_return <= n_return;
            r_move   <= n_move;
            r_delay  <= n_delay;
            r_phase  <= n_phase;
        end
    end

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == goc_pkg::ST_ERROR |-> r_phase <= goc_pkg::LAST_PHASE)
        else $error("blink phase past last phase");

    a_return_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == goc_pkg::ST_EMERG |-> (r_return == goc_pkg::ST_WAIT
            || r_return == goc_pkg::ST_OPENING || r_return == goc_pkg::ST_CLOSING))
        else $error("emergency return state is not a resumable state");

    a_delay_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept |=> r_delay != '1)
        else $error("delay counter reached its maximum");

    a_move_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && r_state != goc_pkg::ST_OPENING && r_state != goc_pkg::ST_CLOSING
        |=> r_move == '0)
        else $error("motion counter not cleared outside motion");

endmodule

// ===== hdl/goc_outbuf.sv =====
module goc_outbuf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  goc_pkg::t_result i_data,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_stall,
    output goc_pkg::t_result o_data
);

    logic             r_main_valid;
    logic             r_skid_valid;
    goc_pkg::t_result r_main;
    goc_pkg::t_result r_skid;
    logic             pop;

    assign pop     = r_main_valid && !i_stall;
    assign o_full  = r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            r_main_valid <= r_skid_valid || i_push;
            r_skid_valid <= 1'b0;
        end else if (!r_main_valid) begin
            r_main_valid <= i_push;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_main <= r_skid_valid ? r_skid : i_data;
        end else if (!r_main_valid) begin
            r_main <= i_data;
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_main_valid)
        else $error("skid entry held without a main entry");

endmodule

// ===== hdl/gate_opener_controller.sv =====
// motorized gate controller, one input transfer per switch sample
//
// input channel: i_in_valid with the five switch bits, o_in_stall back to
// the sender; a transfer happens when valid is high and stall is low
// output channel: o_out_valid with motor, lamp and state code, i_out_stall
// from the receiver
// every input transfer produces exactly one output transfer
// the result of each input transfer is registered in the output buffer
// throughput: one transfer per cycle while o_in_stall is low; next-state logic
// is combinational ahead of the state registers; the result sits in a two-entry
// output buffer, so a new sample is taken while an earlier result still waits
// receiver stall: the second buffer entry absorbs one more result, then
// o_in_stall rises until the receiver takes a result
// config: apb-style port, timeout at 0x0, recheck at 0x4, blink phase at 0x8;
// the user must keep it written only while the block is idle, which the block does not enforce; pready is always high
// reset (synchronous, active low): state init, counters cleared, buffer
// empty, registers back to 3600 / 30 / 10 ticks
module gate_opener_controller (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // apb configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [goc_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [goc_pkg::DATA_BITS-1:0]  pwdata,
    output logic [goc_pkg::DATA_BITS-1:0]  prdata,
    output logic                           pready,
    // switch samples
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_open_limit,
    input  logic                           i_close_limit,
    input  logic                           i_photocell_block,
    input  logic                           i_close_cmd,
    input  logic                           i_open_cmd,
    // drives
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_motor_open,
    output logic                           o_motor_close,
    output logic                           o_led_moving,
    output logic                           o_led_alarm,
    output logic [2:0]                     o_state_code
);

    goc_pkg::t_cfg      cfg;
    goc_pkg::t_switches sw;
    goc_pkg::t_result   step_result;
    goc_pkg::t_result   out_result;
    logic               in_accept;
    logic               buf_full;

    // input transfer only while the output buffer has room
    assign o_in_stall = buf_full;
    assign in_accept  = i_in_valid && !buf_full;

    assign sw.open_limit      = i_open_limit;
    assign sw.close_limit     = i_close_limit;
    assign sw.photocell_block = i_photocell_block;
    assign sw.close_cmd       = i_close_cmd;
    assign sw.open_cmd        = i_open_cmd;

    goc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // state machine advances once per accepted sample
    goc_fsm u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_sw     (sw),
        .i_cfg    (cfg),
        .o_result (step_result)
    );

    // result register plus skid entry
    goc_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_data  (step_result),
        .o_full  (buf_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (out_result)
    );

    assign o_motor_open  = out_result.motor_open;
    assign o_motor_close = out_result.motor_close;
    assign o_led_moving  = out_result.led_moving;
    assign o_led_alarm   = out_result.led_alarm;
    assign o_state_code  = out_result.state_code;

endmodule
